[src/utf8d_pkg.sv]
`default_nettype none
package utf8d_pkg;

	localparam int ByteW = 8;
	localparam int CpW   = 21;
	localparam int OwedW = 2;

	// lead byte patterns: mask and match
	localparam logic [ByteW-1:0] AsciiMask = 8'h80;
	localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
	localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
	localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
	localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
	localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
	localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

	// bytes still owed after each lead form
	localparam logic [OwedW-1:0] OwedNone  = 2'd0;
	localparam logic [OwedW-1:0] OwedOne   = 2'd1;
	localparam logic [OwedW-1:0] OwedTwo   = 2'd2;
	localparam logic [OwedW-1:0] OwedThree = 2'd3;

	// characters that get flagged
	localparam logic [CpW-1:0] CpSpace = 21'h20;
	localparam logic [CpW-1:0] CpTab   = 21'h09;
	localparam logic [CpW-1:0] CpLf    = 21'h0A;
	localparam logic [CpW-1:0] CpCr    = 21'h0D;
	localparam logic [CpW-1:0] CpHyph  = 21'h2D;
	localparam logic [CpW-1:0] CpSlash = 21'h2F;
	localparam logic [CpW-1:0] CpBslsh = 21'h5C;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           is_space;
		logic           is_break;
		logic           bad_lead;
		logic           cut_short;
	} result_t;

endpackage
`default_nettype wire

[src/utf8_stream_decoder.sv]
// utf8 stream decoder: one byte per request in, one code point per request out
// input channel: in_valid / in_stall carry text_byte and end_of_text, where
//   end_of_text marks the final byte of a string
// output channel: out_valid / out_stall carry code_point with is_space,
//   is_break, bad_lead and cut_short flags
// a result appears for an ascii byte, a bad lead byte, the last byte of a
//   multi-byte sequence, or any byte marked end_of_text; other bytes only
//   update the partial code point
// path: an accepted byte goes into the input register, then decode writes
//   its result, if any, into the result register, which drives out_valid
// throughput: one byte per cycle while in_stall is low; decode is a single
//   pass of mask and shift logic between the input and result registers
// stall: out_stall holds a full result register; a full input register then
//   holds and in_stall rises in the same cycle, so nothing is dropped
// reset: arst_n clears both valids, the partial code point and the owed count
`default_nettype none
module utf8_stream_decoder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [utf8d_pkg::ByteW-1:0] text_byte,
	input  wire logic                        end_of_text,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [utf8d_pkg::CpW-1:0]   code_point,
	output logic                             is_space,
	output logic                             is_break,
	output logic                             bad_lead,
	output logic                             cut_short
);

	// input register
	logic                        valid_s1;
	logic [utf8d_pkg::ByteW-1:0] byte_s1;
	logic                        eot_s1;

	// decode state
	logic [utf8d_pkg::CpW-1:0]   partial_q;
	logic [utf8d_pkg::OwedW-1:0] owed_q;

	// result register
	logic                        valid_s2;
	utf8d_pkg::result_t          result_s2;

	logic [utf8d_pkg::CpW-1:0]   partial_nxt;
	logic [utf8d_pkg::OwedW-1:0] owed_nxt;
	logic                        emit;
	utf8d_pkg::result_t          result;
	logic                        s2_free;
	logic                        s1_go;

	// result register can take a new value when empty or being drained
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_go    = valid_s1 && s2_free;
	// input register takes a byte when empty or moving on
	assign in_stall = valid_s1 && !s2_free;

	utf8d_step u_step (
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.partial     (partial_q),
		.owed        (owed_q),
		.partial_nxt (partial_nxt),
		.owed_nxt    (owed_nxt),
		.emit        (emit),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// state only moves when the byte in the input register is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			owed_q    <= utf8d_pkg::OwedNone;
		end else if (s1_go) begin
			partial_q <= partial_nxt;
			owed_q    <= owed_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			result_s2 <= result;
		end
	end

	assign out_valid  = valid_s2;
	assign code_point = result_s2.code_point;
	assign is_space   = result_s2.is_space;
	assign is_break   = result_s2.is_break;
	assign bad_lead   = result_s2.bad_lead;
	assign cut_short  = result_s2.cut_short;

endmodule
`default_nettype wire

[src/utf8d_step.sv]
`default_nettype none
// one byte of decode: next state and an optional result
module utf8d_step (
	input  wire logic [utf8d_pkg::ByteW-1:0] text_byte,
	input  wire logic                        end_of_text,
	input  wire logic [utf8d_pkg::CpW-1:0]   partial,
	input  wire logic [utf8d_pkg::OwedW-1:0] owed,
	output logic      [utf8d_pkg::CpW-1:0]   partial_nxt,
	output logic      [utf8d_pkg::OwedW-1:0] owed_nxt,
	output logic                             emit,
	output utf8d_pkg::result_t               result
);

	logic [utf8d_pkg::CpW-1:0] cp;
	logic [utf8d_pkg::CpW-1:0] cont_bits;
	logic                      bad;
	logic                      cut;
	logic                      sp;

	always_comb begin
		partial_nxt = partial;
		owed_nxt    = owed;
		emit        = 1'b0;
		cp          = '0;
		bad         = 1'b0;
		cut         = 1'b0;
		cont_bits   = {15'b0, text_byte[5:0]};
		if (owed == utf8d_pkg::OwedNone) begin
			if ((text_byte & utf8d_pkg::AsciiMask) == '0) begin
				emit = 1'b1;
				cp   = {13'b0, text_byte};
			end else if ((text_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
				partial_nxt = {10'b0, text_byte[4:0], 6'b0};
				owed_nxt    = utf8d_pkg::OwedOne;
			end else if ((text_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
				partial_nxt = {5'b0, text_byte[3:0], 12'b0};
				owed_nxt    = utf8d_pkg::OwedTwo;
			end else if ((text_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
				partial_nxt = {text_byte[2:0], 18'b0};
				owed_nxt    = utf8d_pkg::OwedThree;
			end else begin
				emit = 1'b1;
				bad  = 1'b1;
			end
			// multi-byte lead on the last byte: flush what we have
			if (!emit && end_of_text) begin
				emit        = 1'b1;
				cut         = 1'b1;
				cp          = partial_nxt;
				partial_nxt = '0;
				owed_nxt    = utf8d_pkg::OwedNone;
			end
		end else begin
			// continuation bits land at 6 * (owed - 1)
			unique case (owed)
				utf8d_pkg::OwedTwo:   cp = partial | (cont_bits << 6);
				utf8d_pkg::OwedThree: cp = partial | (cont_bits << 12);
				default:              cp = partial | cont_bits;
			endcase
			owed_nxt    = owed - 2'd1;
			partial_nxt = cp;
			if (owed_nxt == utf8d_pkg::OwedNone) begin
				emit        = 1'b1;
				partial_nxt = '0;
			end else if (end_of_text) begin
				emit        = 1'b1;
				cut         = 1'b1;
				partial_nxt = '0;
				owed_nxt    = utf8d_pkg::OwedNone;
			end
		end
	end

	assign sp = (cp == utf8d_pkg::CpSpace) || (cp == utf8d_pkg::CpTab) ||
		(cp == utf8d_pkg::CpLf) || (cp == utf8d_pkg::CpCr);

	assign result.code_point = cp;
	assign result.is_space   = sp;
	assign result.is_break   = sp || (cp == utf8d_pkg::CpHyph) ||
		(cp == utf8d_pkg::CpSlash) || (cp == utf8d_pkg::CpBslsh);
	assign result.bad_lead   = bad;
	assign result.cut_short  = cut;

endmodule
`default_nettype wire
